// ----- src/nsp_pkg.sv -----
// nearest segment pick: shared constants, register indexes and the sequencer state type
`timescale 1ns / 1ps
package nsp_pkg;

  localparam int COORD_W    = 16;
  localparam int DELTA_W    = 17;
  localparam int SCALE_W    = 17;
  localparam int PIX_W      = 12;
  localparam int IDX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int LIMIT_W    = 17;
  localparam int DIST_W     = 40;
  localparam int SUM_W      = 32;
  localparam int LEN_W      = 34;
  localparam int NEAR_W     = 15;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_SCALE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_OFFSET_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_OFFSET_Y = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd6144;

  localparam int SECTOR_LIMIT = 256;
  localparam int WALL_LIMIT   = 256;

  // pick radius 7 pixels, squared, in q.24
  localparam logic [DIST_W-1:0] PICK_RADIUS_SQ = 40'd49 << 24;
  // 7 pixels in q.12
  localparam int FAR_LIMIT = 7 * 4096;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AX,
    ST_AY,
    ST_LX,
    ST_LY,
    ST_Q,
    ST_PX,
    ST_PY,
    ST_CLAMP,
    ST_DIV,
    ST_EX,
    ST_SX,
    ST_EY,
    ST_SY,
    ST_CHECK,
    ST_DX2,
    ST_DY2,
    ST_UPDATE,
    ST_FINISH
  } state_t;

endpackage

// ----- src/nsp_in_if.sv -----
// segment request channel
`timescale 1ns / 1ps
interface nsp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [nsp_pkg::COORD_W-1:0]  start_x;
  logic signed [nsp_pkg::COORD_W-1:0]  start_y;
  logic signed [nsp_pkg::COORD_W-1:0]  end_x;
  logic signed [nsp_pkg::COORD_W-1:0]  end_y;
  logic        [nsp_pkg::PIX_W-1:0]    cursor_x;
  logic        [nsp_pkg::PIX_W-1:0]    cursor_y;
  logic        [nsp_pkg::IDX_W-1:0]    sector_index;
  logic        [nsp_pkg::IDX_W-1:0]    wall_index;
  logic                                first_item;
  logic                                last_item;

  modport source (
    output valid, start_x, start_y, end_x, end_y, cursor_x, cursor_y,
           sector_index, wall_index, first_item, last_item,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, cursor_x, cursor_y,
           sector_index, wall_index, first_item, last_item,
    output ready
  );
endinterface

// ----- src/nsp_out_if.sv -----
// pick result channel
`timescale 1ns / 1ps
interface nsp_out_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic        [nsp_pkg::IDX_W-1:0]   hit_sector;
  logic        [nsp_pkg::IDX_W-1:0]   hit_wall;
  logic signed [nsp_pkg::COORD_W-1:0] foot_x;
  logic signed [nsp_pkg::COORD_W-1:0] foot_y;

  modport source (output valid, hit, hit_sector, hit_wall, foot_x, foot_y, input ready);
  modport sink   (input valid, hit, hit_sector, hit_wall, foot_x, foot_y, output ready);
endinterface

// ----- src/nsp_cfg_if.sv -----
// configuration write channel
`timescale 1ns / 1ps
interface nsp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [nsp_pkg::CFG_IDX_W-1:0]     index;
  logic [nsp_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/nsp_serial_mul.sv -----
// shift-and-add multiplier, one multiplier bit per cycle, signed by unsigned
`timescale 1ns / 1ps
module nsp_serial_mul #(
  parameter int A_W = 36,
  parameter int B_W = 17,
  parameter int P_W = 54
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [A_W-1:0] a,
  input  logic        [B_W-1:0] b,
  output logic                  done,
  output logic signed [P_W-1:0] prod
);

  logic                  run_r, run_nxt;
  logic signed [P_W-1:0] acc_r, acc_nxt;
  logic signed [P_W-1:0] a_r, a_nxt;
  logic        [B_W-1:0] b_r, b_nxt;

  always_comb begin
    run_nxt = run_r;
    acc_nxt = acc_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    if (start) begin
      run_nxt = 1'b1;
      acc_nxt = '0;
      a_nxt   = P_W'(a);
      b_nxt   = b;
    end else if (run_r) begin
      if (b_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        if (b_r[0]) begin
          acc_nxt = acc_r + a_r;
        end
        a_nxt = a_r <<< 1;
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  // finished once no multiplier bits are left
  assign done = run_r && (b_r == '0);
  assign prod = acc_r;

endmodule

// ----- src/nearest_segment_pick.sv -----
// nearest segment pick: top level with sequencer, divider and best-match store
`timescale 1ns / 1ps
// Takes a search as a stream of wall segment requests and returns, on the request marked
// last_item, one result: whether any segment came within 7 pixels of the cursor, the sector
// and wall of the strictly closest one (first one wins a tie) and the world foot point on it.
// Each request is handled alone from start to finish; in_ch.ready is high only while the
// block is idle, while a finished result may still wait in the output register. The time
// is set by the single shared shift-and-add multiplier, which forms up to thirteen products
// in turn. Each product starts the multiplier, takes one step per significant bit of its
// multiplier operand and is then collected. The restoring divider forms T_FRAC_BITS
// quotient bits of the foot parameter when it is not clamped. Zero-length segments stop
// after seven products. A segment that is 7 pixels or more away on either axis skips the
// two squaring products. A last request waits in the finish step while the output
// register is still full and not being taken. Configuration writes are always accepted
// and should only be made while idle.
module nearest_segment_pick #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  nsp_in_if.sink    in_ch,
  nsp_out_if.source out_ch,
  nsp_cfg_if.sink   cfg_ch
);

  localparam int TF = T_FRAC_BITS;
  localparam int TW = TF + 1;                        // t in q1.TF, up to one
  localparam int MB = (TW > 17) ? TW : 17;           // multiplier operand width
  localparam int EW = nsp_pkg::DELTA_W + TW;         // delta times t
  localparam int MA = (EW > 36) ? EW : 36;           // multiplicand width
  localparam int PW = MA + MB + 1;                   // product width
  localparam int CW = $clog2(TF);                    // divider step counter

  localparam logic signed [PW-1:0] HALF_T = {{(PW-1){1'b0}}, 1'b1} << (TF - 1);

  // configuration
  logic        [nsp_pkg::SCALE_W-1:0] scale_r;
  logic signed [nsp_pkg::COORD_W-1:0] offx_r, offy_r;

  // current segment
  nsp_pkg::state_t state_r, state_nxt;
  logic                                ph_r, ph_nxt;
  logic signed [nsp_pkg::COORD_W-1:0]  axw_r, axw_nxt, ayw_r, ayw_nxt;
  logic signed [nsp_pkg::DELTA_W-1:0]  dxw_r, dxw_nxt, dyw_r, dyw_nxt;
  logic        [nsp_pkg::PIX_W-1:0]    mx_r, mx_nxt, my_r, my_nxt;
  logic        [nsp_pkg::IDX_W-1:0]    sec_r, sec_nxt, wal_r, wal_nxt;
  logic                                last_r, last_nxt;
  logic signed [MA-1:0]                relx_r, relx_nxt, rely_r, rely_nxt;
  logic        [nsp_pkg::LEN_W-1:0]    lw_r, lw_nxt;
  logic signed [PW-1:0]                q_r, q_nxt, p_r, p_nxt, rem_r, rem_nxt;
  logic        [CW-1:0]                cnt_r, cnt_nxt;
  logic        [TW-1:0]                tq_r, tq_nxt;
  logic signed [EW-1:0]                ex_r, ex_nxt, ey_r, ey_nxt;
  logic signed [nsp_pkg::COORD_W-1:0]  fx_r, fx_nxt, fy_r, fy_nxt;
  logic signed [PW-1:0]                dx_r, dx_nxt, dy_r, dy_nxt;
  logic        [nsp_pkg::NEAR_W-1:0]   nx_r, nx_nxt, ny_r, ny_nxt;
  logic        [nsp_pkg::SUM_W-1:0]    d_r, d_nxt;

  // best match of the running search
  logic [nsp_pkg::DIST_W-1:0]          best_dist_r, best_dist_nxt;
  logic                                best_found_r, best_found_nxt;
  logic [nsp_pkg::IDX_W-1:0]           best_sec_r, best_sec_nxt, best_wal_r, best_wal_nxt;
  logic signed [nsp_pkg::COORD_W-1:0]  best_fx_r, best_fx_nxt, best_fy_r, best_fy_nxt;

  // result register
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_hit_r, out_hit_nxt;
  logic [nsp_pkg::IDX_W-1:0]           out_sec_r, out_sec_nxt, out_wal_r, out_wal_nxt;
  logic signed [nsp_pkg::COORD_W-1:0]  out_fx_r, out_fx_nxt, out_fy_r, out_fy_nxt;

  // shared multiplier
  logic                 mul_start, mul_done;
  logic signed [MA-1:0] mul_a;
  logic        [MB-1:0] mul_b;
  logic signed [PW-1:0] mul_prod;

  logic [nsp_pkg::COORD_W-1:0] adx, ady;

  nsp_serial_mul #(
    .A_W (MA),
    .B_W (MB),
    .P_W (PW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // magnitudes of the world deltas, always below 2^16
  assign adx = dxw_r[nsp_pkg::DELTA_W-1] ? nsp_pkg::COORD_W'(-dxw_r) : nsp_pkg::COORD_W'(dxw_r);
  assign ady = dyw_r[nsp_pkg::DELTA_W-1] ? nsp_pkg::COORD_W'(-dyw_r) : nsp_pkg::COORD_W'(dyw_r);

  // multiplier operand selection per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      nsp_pkg::ST_AX: begin
        mul_a = MA'(axw_r);
        mul_b = MB'(scale_r);
      end
      nsp_pkg::ST_AY: begin
        mul_a = MA'(ayw_r);
        mul_b = MB'(scale_r);
      end
      nsp_pkg::ST_LX: begin
        mul_a = MA'($signed({1'b0, adx}));
        mul_b = MB'(adx);
      end
      nsp_pkg::ST_LY: begin
        mul_a = MA'($signed({1'b0, ady}));
        mul_b = MB'(ady);
      end
      nsp_pkg::ST_Q: begin
        mul_a = MA'($signed({1'b0, lw_r}));
        mul_b = MB'(scale_r);
      end
      nsp_pkg::ST_PX: begin
        mul_a = relx_r;
        mul_b = MB'(adx);
      end
      nsp_pkg::ST_PY: begin
        mul_a = rely_r;
        mul_b = MB'(ady);
      end
      nsp_pkg::ST_EX: begin
        mul_a = MA'(dxw_r);
        mul_b = MB'(tq_r);
      end
      nsp_pkg::ST_SX: begin
        mul_a = MA'(ex_r);
        mul_b = MB'(scale_r);
      end
      nsp_pkg::ST_EY: begin
        mul_a = MA'(dyw_r);
        mul_b = MB'(tq_r);
      end
      nsp_pkg::ST_SY: begin
        mul_a = MA'(ey_r);
        mul_b = MB'(scale_r);
      end
      nsp_pkg::ST_DX2: begin
        mul_a = MA'($signed({1'b0, nx_r}));
        mul_b = MB'(nx_r);
      end
      nsp_pkg::ST_DY2: begin
        mul_a = MA'($signed({1'b0, ny_r}));
        mul_b = MB'(ny_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer: next state and datapath
  always_comb begin
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] ax_full;
    logic signed [PW-1:0] cur;
    logic signed [PW-1:0] rem2;
    logic signed [PW-1:0] ax_abs;
    logic signed [PW-1:0] ay_abs;
    logic                 is_mul;
    logic                 idx_ok;
    logic                 take;

    state_nxt      = state_r;
    ph_nxt         = ph_r;
    axw_nxt        = axw_r;
    ayw_nxt        = ayw_r;
    dxw_nxt        = dxw_r;
    dyw_nxt        = dyw_r;
    mx_nxt         = mx_r;
    my_nxt         = my_r;
    sec_nxt        = sec_r;
    wal_nxt        = wal_r;
    last_nxt       = last_r;
    relx_nxt       = relx_r;
    rely_nxt       = rely_r;
    lw_nxt         = lw_r;
    q_nxt          = q_r;
    p_nxt          = p_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    tq_nxt         = tq_r;
    ex_nxt         = ex_r;
    ey_nxt         = ey_r;
    fx_nxt         = fx_r;
    fy_nxt         = fy_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    nx_nxt         = nx_r;
    ny_nxt         = ny_r;
    d_nxt          = d_r;
    best_dist_nxt  = best_dist_r;
    best_found_nxt = best_found_r;
    best_sec_nxt   = best_sec_r;
    best_wal_nxt   = best_wal_r;
    best_fx_nxt    = best_fx_r;
    best_fy_nxt    = best_fy_r;
    out_valid_nxt  = out_valid_r;
    out_hit_nxt    = out_hit_r;
    out_sec_nxt    = out_sec_r;
    out_wal_nxt    = out_wal_r;
    out_fx_nxt     = out_fx_r;
    out_fy_nxt     = out_fy_r;
    mul_start      = 1'b0;
    in_ch.ready    = 1'b0;

    rnd     = (mul_prod + HALF_T) >>> TF;
    ax_full = '0;
    cur     = '0;
    rem2    = rem_r <<< 1;
    ax_abs  = dx_r[PW-1] ? -dx_r : dx_r;
    ay_abs  = dy_r[PW-1] ? -dy_r : dy_r;
    idx_ok  = ({{(nsp_pkg::LIMIT_W-nsp_pkg::IDX_W){1'b0}}, sec_r}
               < nsp_pkg::LIMIT_W'(nsp_pkg::SECTOR_LIMIT))
           && ({{(nsp_pkg::LIMIT_W-nsp_pkg::IDX_W){1'b0}}, wal_r}
               < nsp_pkg::LIMIT_W'(nsp_pkg::WALL_LIMIT));

    // result register drains independently of the sequencer
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // every product step: start the multiplier, then wait for it
    is_mul = (state_r != nsp_pkg::ST_IDLE) && (state_r != nsp_pkg::ST_CLAMP)
          && (state_r != nsp_pkg::ST_DIV) && (state_r != nsp_pkg::ST_CHECK)
          && (state_r != nsp_pkg::ST_UPDATE) && (state_r != nsp_pkg::ST_FINISH);
    take = is_mul && ph_r && mul_done;
    if (is_mul && !ph_r) begin
      mul_start = 1'b1;
      ph_nxt    = 1'b1;
    end
    if (take) begin
      ph_nxt = 1'b0;
    end

    unique case (state_r)
      nsp_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          axw_nxt  = in_ch.start_x;
          ayw_nxt  = in_ch.start_y;
          dxw_nxt  = $signed({in_ch.end_x[nsp_pkg::COORD_W-1], in_ch.end_x})
                   - $signed({in_ch.start_x[nsp_pkg::COORD_W-1], in_ch.start_x});
          dyw_nxt  = $signed({in_ch.end_y[nsp_pkg::COORD_W-1], in_ch.end_y})
                   - $signed({in_ch.start_y[nsp_pkg::COORD_W-1], in_ch.start_y});
          mx_nxt   = in_ch.cursor_x;
          my_nxt   = in_ch.cursor_y;
          sec_nxt  = in_ch.sector_index;
          wal_nxt  = in_ch.wall_index;
          last_nxt = in_ch.last_item;
          if (in_ch.first_item) begin
            best_dist_nxt  = nsp_pkg::PICK_RADIUS_SQ;
            best_found_nxt = 1'b0;
            best_sec_nxt   = '0;
            best_wal_nxt   = '0;
            best_fx_nxt    = '0;
            best_fy_nxt    = '0;
          end
          state_nxt = nsp_pkg::ST_AX;
        end
      end
      nsp_pkg::ST_AX: begin
        if (take) begin
          // screen start x = offset + world x times scale, all in q.12
          ax_full   = (PW'(offx_r) <<< 8) + mul_prod;
          cur       = $signed(PW'({mx_r, 12'b0}));
          relx_nxt  = MA'(cur - ax_full);
          state_nxt = nsp_pkg::ST_AY;
        end
      end
      nsp_pkg::ST_AY: begin
        if (take) begin
          // y is flipped on screen
          ax_full   = (PW'(offy_r) <<< 8) - mul_prod;
          cur       = $signed(PW'({my_r, 12'b0}));
          rely_nxt  = MA'(cur - ax_full);
          state_nxt = nsp_pkg::ST_LX;
        end
      end
      nsp_pkg::ST_LX: begin
        if (take) begin
          lw_nxt    = nsp_pkg::LEN_W'(mul_prod);
          state_nxt = nsp_pkg::ST_LY;
        end
      end
      nsp_pkg::ST_LY: begin
        if (take) begin
          lw_nxt    = lw_r + nsp_pkg::LEN_W'(mul_prod);
          state_nxt = nsp_pkg::ST_Q;
        end
      end
      nsp_pkg::ST_Q: begin
        if (take) begin
          q_nxt     = mul_prod;
          state_nxt = nsp_pkg::ST_PX;
        end
      end
      nsp_pkg::ST_PX: begin
        if (take) begin
          p_nxt     = dxw_r[nsp_pkg::DELTA_W-1] ? -mul_prod : mul_prod;
          state_nxt = nsp_pkg::ST_PY;
        end
      end
      nsp_pkg::ST_PY: begin
        if (take) begin
          p_nxt     = dyw_r[nsp_pkg::DELTA_W-1] ? p_r + mul_prod : p_r - mul_prod;
          state_nxt = nsp_pkg::ST_CLAMP;
        end
      end
      nsp_pkg::ST_CLAMP: begin
        // zero-length segment or index out of range: no candidate
        if (!idx_ok || q_r == '0) begin
          state_nxt = nsp_pkg::ST_FINISH;
        end else if (p_r <= PW'(0)) begin
          tq_nxt    = '0;
          state_nxt = nsp_pkg::ST_EX;
        end else if (p_r >= q_r) begin
          tq_nxt    = TW'(1) << TF;
          state_nxt = nsp_pkg::ST_EX;
        end else begin
          rem_nxt   = p_r;
          tq_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = nsp_pkg::ST_DIV;
        end
      end
      nsp_pkg::ST_DIV: begin
        // restoring division, one quotient bit a cycle
        if (rem2 >= q_r) begin
          rem_nxt = rem2 - q_r;
          tq_nxt  = {tq_r[TW-2:0], 1'b1};
        end else begin
          rem_nxt = rem2;
          tq_nxt  = {tq_r[TW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(TF - 1)) begin
          state_nxt = nsp_pkg::ST_EX;
        end
      end
      nsp_pkg::ST_EX: begin
        if (take) begin
          ex_nxt    = EW'(mul_prod);
          fx_nxt    = nsp_pkg::COORD_W'(PW'(axw_r) + rnd);
          state_nxt = nsp_pkg::ST_SX;
        end
      end
      nsp_pkg::ST_SX: begin
        if (take) begin
          dx_nxt    = PW'(relx_r) - rnd;
          state_nxt = nsp_pkg::ST_EY;
        end
      end
      nsp_pkg::ST_EY: begin
        if (take) begin
          ey_nxt    = EW'(mul_prod);
          fy_nxt    = nsp_pkg::COORD_W'(PW'(ayw_r) + rnd);
          state_nxt = nsp_pkg::ST_SY;
        end
      end
      nsp_pkg::ST_SY: begin
        if (take) begin
          dy_nxt    = PW'(rely_r) + rnd;
          state_nxt = nsp_pkg::ST_CHECK;
        end
      end
      nsp_pkg::ST_CHECK: begin
        // either component 7 pixels or more cannot win
        if (ax_abs >= PW'(nsp_pkg::FAR_LIMIT) || ay_abs >= PW'(nsp_pkg::FAR_LIMIT)) begin
          state_nxt = nsp_pkg::ST_FINISH;
        end else begin
          nx_nxt    = nsp_pkg::NEAR_W'(ax_abs);
          ny_nxt    = nsp_pkg::NEAR_W'(ay_abs);
          state_nxt = nsp_pkg::ST_DX2;
        end
      end
      nsp_pkg::ST_DX2: begin
        if (take) begin
          d_nxt     = nsp_pkg::SUM_W'(mul_prod);
          state_nxt = nsp_pkg::ST_DY2;
        end
      end
      nsp_pkg::ST_DY2: begin
        if (take) begin
          d_nxt     = d_r + nsp_pkg::SUM_W'(mul_prod);
          state_nxt = nsp_pkg::ST_UPDATE;
        end
      end
      nsp_pkg::ST_UPDATE: begin
        // strictly closer only, so the first of equals stays
        if (nsp_pkg::DIST_W'(d_r) < best_dist_r) begin
          best_dist_nxt  = nsp_pkg::DIST_W'(d_r);
          best_found_nxt = 1'b1;
          best_sec_nxt   = sec_r;
          best_wal_nxt   = wal_r;
          best_fx_nxt    = fx_r;
          best_fy_nxt    = fy_r;
        end
        state_nxt = nsp_pkg::ST_FINISH;
      end
      nsp_pkg::ST_FINISH: begin
        if (!last_r) begin
          state_nxt = nsp_pkg::ST_IDLE;
        end else if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = best_found_r;
          out_sec_nxt    = best_sec_r;
          out_wal_nxt    = best_wal_r;
          out_fx_nxt     = best_fx_r;
          out_fy_nxt     = best_fy_r;
          best_dist_nxt  = nsp_pkg::PICK_RADIUS_SQ;
          best_found_nxt = 1'b0;
          best_sec_nxt   = '0;
          best_wal_nxt   = '0;
          best_fx_nxt    = '0;
          best_fy_nxt    = '0;
          state_nxt      = nsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nsp_pkg::ST_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nsp_pkg::ST_IDLE;
      ph_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      best_dist_r  <= nsp_pkg::PICK_RADIUS_SQ;
      best_found_r <= 1'b0;
      best_sec_r   <= '0;
      best_wal_r   <= '0;
      best_fx_r    <= '0;
      best_fy_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      ph_r         <= ph_nxt;
      out_valid_r  <= out_valid_nxt;
      best_dist_r  <= best_dist_nxt;
      best_found_r <= best_found_nxt;
      best_sec_r   <= best_sec_nxt;
      best_wal_r   <= best_wal_nxt;
      best_fx_r    <= best_fx_nxt;
      best_fy_r    <= best_fy_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    axw_r     <= axw_nxt;
    ayw_r     <= ayw_nxt;
    dxw_r     <= dxw_nxt;
    dyw_r     <= dyw_nxt;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    sec_r     <= sec_nxt;
    wal_r     <= wal_nxt;
    last_r    <= last_nxt;
    relx_r    <= relx_nxt;
    rely_r    <= rely_nxt;
    lw_r      <= lw_nxt;
    q_r       <= q_nxt;
    p_r       <= p_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    tq_r      <= tq_nxt;
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    fx_r      <= fx_nxt;
    fy_r      <= fy_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    nx_r      <= nx_nxt;
    ny_r      <= ny_nxt;
    d_r       <= d_nxt;
    out_hit_r <= out_hit_nxt;
    out_sec_r <= out_sec_nxt;
    out_wal_r <= out_wal_nxt;
    out_fx_r  <= out_fx_nxt;
    out_fy_r  <= out_fy_nxt;
  end

  // configuration registers, always writable
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= nsp_pkg::SCALE_RESET;
      offx_r  <= '0;
      offy_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        nsp_pkg::REG_VIEW_SCALE:    scale_r <= cfg_ch.data[nsp_pkg::SCALE_W-1:0];
        nsp_pkg::REG_VIEW_OFFSET_X: offx_r  <= $signed(cfg_ch.data[nsp_pkg::COORD_W-1:0]);
        nsp_pkg::REG_VIEW_OFFSET_Y: offy_r  <= $signed(cfg_ch.data[nsp_pkg::COORD_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // result outputs
  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.hit_sector = out_sec_r;
  assign out_ch.hit_wall   = out_wal_r;
  assign out_ch.foot_x     = out_fx_r;
  assign out_ch.foot_y     = out_fy_r;

  // multiplier only finishes while the sequencer waits on it
  a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> ph_r)
    else $error("multiplier finished outside a wait step");

  // divider never runs past the last quotient bit
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nsp_pkg::ST_DIV) |-> (cnt_r <= CW'(TF - 1)))
    else $error("divider step count overran");

  // a recorded match always lies inside the pick radius
  a_best_inside: assert property (@(posedge clk) disable iff (!rst_n)
    best_found_r |-> (best_dist_r < nsp_pkg::PICK_RADIUS_SQ))
    else $error("best match outside pick radius");

  // with no match the reported fields stay zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !best_found_r |-> (best_sec_r == '0 && best_wal_r == '0
                       && best_fx_r == '0 && best_fy_r == '0))
    else $error("stale match fields without a hit");

  // a result is only loaded when the search was marked last
  a_emit_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && out_valid_nxt) |-> (state_r == nsp_pkg::ST_FINISH && last_r))
    else $error("result emitted without a last request");

endmodule
